// File: src/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared constants, tables and helper functions of the capacitor time-constant check.
// ----------------------------------------------------------------------------
package ctc_pkg;

    localparam int NPTS = 10;

    // Expected fraction of the voltage swing at each time point, Q16.
    function automatic logic signed [31:0] charge_frac(input logic [3:0] j);
        logic signed [31:0] r;
        begin
            r = 32'sd0;
            unique case (j)
                4'd0: r = 32'sd11796;
                4'd1: r = 32'sd21626;
                4'd2: r = 32'sd29491;
                4'd3: r = 32'sd36044;
                4'd4: r = 32'sd41287;
                4'd5: r = 32'sd48234;
                4'd6: r = 32'sd53084;
                4'd7: r = 32'sd56688;
                4'd8: r = 32'sd60162;
                4'd9: r = 32'sd62259;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] discharge_frac(input logic [3:0] j);
        logic signed [31:0] r;
        begin
            r = 32'sd0;
            unique case (j)
                4'd0: r = 32'sd53739;
                4'd1: r = 32'sd43909;
                4'd2: r = 32'sd36044;
                4'd3: r = 32'sd29491;
                4'd4: r = 32'sd24248;
                4'd5: r = 32'sd17301;
                4'd6: r = 32'sd12451;
                4'd7: r = 32'sd8847;
                4'd8: r = 32'sd5373;
                4'd9: r = 32'sd3276;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    // Multiples of RC at which samples are taken, Q24.
    function automatic logic [25:0] time_mult(input logic [3:0] j);
        logic [25:0] r;
        begin
            r = 26'd0;
            unique case (j)
                4'd0: r = 26'd3355443;
                4'd1: r = 26'd6710886;
                4'd2: r = 26'd10066329;
                4'd3: r = 26'd13421772;
                4'd4: r = 26'd16777216;
                4'd5: r = 26'd22313697;
                4'd6: r = 26'd27850178;
                4'd7: r = 26'd33554432;
                4'd8: r = 26'd41943040;
                4'd9: r = 26'd50331648;
                default: r = 26'd0;
            endcase
            return r;
        end
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -66'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// File: src/ctc_div.sv
// ----------------------------------------------------------------------------
// ctc_div
// Iterative Q16 divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module ctc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    import ctc_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        nsign_reg, nsign_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic signed [49:0] sq;

    // Restoring division over magnitudes of a*2^16 and b.
    always_comb
    begin
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        nsign_next = nsign_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[31:0], dvd_reg[47]} - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = 6'd48;
            neg_next   = num[31] ^ den[31];
            zero_next  = (den == 32'sd0);
            nsign_next = num[31];
            dvd_next   = {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            dvs_next   = den[31] ? 32'(-den) : 32'(den);
            rem_next   = 33'd0;
            q_next     = 48'd0;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], dvd_reg[47]};
                q_next   = {q_reg[46:0], 1'b0};
            end
            dvd_next = {dvd_reg[46:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        nsign_reg <= nsign_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
    end

    // Apply sign and saturate; zero divisor gives the signed extreme.
    assign sq   = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign done = done_reg;
    always_comb
    begin
        if (zero_reg)
            quot = nsign_reg ? 32'sh80000000 : 32'sh7fffffff;
        else
            quot = sat32(66'(sq));
    end
endmodule

// File: src/ctc_mul.sv
// ----------------------------------------------------------------------------
// ctc_mul
// Registered 32x32 signed multiplier with arithmetic shift and saturation.
// ----------------------------------------------------------------------------
module ctc_mul
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic               q24,
    output logic signed [31:0] p
);
    import ctc_pkg::*;

    logic signed [63:0] prod_reg;
    logic               q24_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        q24_reg  <= q24;
    end

    // Floor shift then clamp to 32 bits.
    always_comb
    begin
        if (q24_reg)
            p = sat32(66'(prod_reg >>> 24));
        else
            p = sat32(66'(prod_reg >>> 16));
    end
endmodule

// File: src/capacitor_time_constant_check.sv
// ----------------------------------------------------------------------------
// capacitor_time_constant_check
// Work per item: a sample-point check runs up to eight divisions on the
// shared divider; other ticks need no division.
// Throughput: one item at a time; s_tready is low while an item is in work.
// Reset: asynchronous, active low; clears the control state and samples, loads register defaults.
// ----------------------------------------------------------------------------
module capacitor_time_constant_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], voltage[33:2], zero[39:34]
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // running, alarm, predicted_time, deviation, point_index
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ctc_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_TB   = 5'd1;
    localparam logic [4:0] ST_TM   = 5'd2;
    localparam logic [4:0] ST_TW   = 5'd3;
    localparam logic [4:0] ST_ELP  = 5'd4;
    localparam logic [4:0] ST_FR   = 5'd5;
    localparam logic [4:0] ST_FRW  = 5'd6;
    localparam logic [4:0] ST_TG   = 5'd7;
    localparam logic [4:0] ST_TGW  = 5'd8;
    localparam logic [4:0] ST_K    = 5'd9;
    localparam logic [4:0] ST_KW   = 5'd10;
    localparam logic [4:0] ST_M1   = 5'd11;
    localparam logic [4:0] ST_M1W  = 5'd12;
    localparam logic [4:0] ST_M2   = 5'd13;
    localparam logic [4:0] ST_M2W  = 5'd14;
    localparam logic [4:0] ST_B    = 5'd15;
    localparam logic [4:0] ST_BW   = 5'd16;
    localparam logic [4:0] ST_T    = 5'd17;
    localparam logic [4:0] ST_TWT  = 5'd18;
    localparam logic [4:0] ST_P1   = 5'd19;
    localparam logic [4:0] ST_P1W  = 5'd20;
    localparam logic [4:0] ST_P2   = 5'd21;
    localparam logic [4:0] ST_P2W  = 5'd22;
    localparam logic [4:0] ST_DEC  = 5'd23;
    localparam logic [4:0] ST_OUT  = 5'd24;
    localparam logic [4:0] ST_CHK  = 5'd25;

    localparam logic [2:0] R_FULL = 3'd0;
    localparam logic [2:0] R_TAU  = 3'd1;
    localparam logic [2:0] R_TICK = 3'd2;
    localparam logic [2:0] R_UPP  = 3'd3;
    localparam logic [2:0] R_LOW  = 3'd4;

    // Configuration registers.
    logic [30:0]        full_reg, tau_reg, tick_reg;
    logic signed [31:0] upp_reg, low_reg;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 31'd0;
            tau_reg  <= 31'd65536;
            tick_reg <= 31'd16777;
            upp_reg  <= 32'sd1310720;
            low_reg  <= -32'sd1310720;
        end
        else if (wr)
        begin
            unique case (paddr[4:2])
                R_FULL:  full_reg <= pwdata[30:0];
                R_TAU:   tau_reg  <= pwdata[30:0];
                R_TICK:  tick_reg <= pwdata[30:0];
                R_UPP:   upp_reg  <= pwdata;
                R_LOW:   low_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            R_FULL:  prdata = {1'b0, full_reg};
            R_TAU:   prdata = {1'b0, tau_reg};
            R_TICK:  prdata = {1'b0, tick_reg};
            R_UPP:   prdata = upp_reg;
            R_LOW:   prdata = low_reg;
            default: prdata = 32'd0;
        endcase
    end

    // Block state.
    logic [4:0]         st_reg, st_next;
    logic signed [31:0] elp_reg, elp_next;
    logic [3:0]         pc_reg, pc_next;
    logic signed [31:0] smp_reg [NPTS];
    logic signed [31:0] tpt_reg [NPTS];
    logic signed [31:0] sv_reg, sv_next;
    logic [1:0]         pm_reg, pm_next;
    logic signed [31:0] lp_reg, lp_next;
    logic signed [31:0] ld_reg, ld_next;
    logic               run_reg, run_next;
    logic               alm_reg, alm_next;
    logic [1:0]         md_reg, md_next;
    logic signed [31:0] vin_reg, vin_next;
    logic [3:0]         ti_reg, ti_next;
    logic [3:0]         fi_reg, fi_next;
    logic [3:0]         pj_reg, pj_next;
    logic               fall_reg, fall_next;
    logic signed [31:0] den_reg, den_next;
    logic signed [31:0] k_reg, k_next;
    logic signed [31:0] m1_reg, m1_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] tg_reg, tg_next;
    logic signed [31:0] pa_reg, pa_next;
    logic               smp_clr, smp_wr, tpt_wr;
    logic signed [31:0] tpt_val;

    // Shared units.
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_den, div_q;
    logic signed [31:0] mul_a, mul_b, mul_p;
    logic               mul_q24;
    logic signed [31:0] base;
    logic [56:0]        tprod;
    logic signed [31:0] fr;

    ctc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    ctc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q24 (mul_q24),
        .p   (mul_p)
    );

    assign base  = sat32(66'($signed({1'b0, tau_reg, 8'd0})));
    assign tprod = {31'd0, time_mult(ti_reg)} * {25'd0, base};
    assign fr    = (md_reg == 2'd2) ? discharge_frac(pj_reg) : charge_frac(pj_reg);

    always_comb
    begin
        st_next   = st_reg;
        elp_next  = elp_reg;
        pc_next   = pc_reg;
        sv_next   = sv_reg;
        pm_next   = pm_reg;
        lp_next   = lp_reg;
        ld_next   = ld_reg;
        run_next  = run_reg;
        alm_next  = alm_reg;
        md_next   = md_reg;
        vin_next  = vin_reg;
        ti_next   = ti_reg;
        fi_next   = fi_reg;
        pj_next   = pj_reg;
        fall_next = fall_reg;
        den_next  = den_reg;
        k_next    = k_reg;
        m1_next   = m1_reg;
        b_next    = b_reg;
        t_next    = t_reg;
        tg_next   = tg_reg;
        pa_next   = pa_reg;
        smp_clr   = 1'b0;
        smp_wr    = 1'b0;
        tpt_wr    = 1'b0;
        tpt_val   = 32'sd0;
        div_start = 1'b0;
        div_num   = 32'sd0;
        div_den   = 32'sd0;
        mul_a     = 32'sd0;
        mul_b     = 32'sd0;
        mul_q24   = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    md_next  = s_tdata[1:0];
                    vin_next = s_tdata[33:2];
                    if (s_tuser)
                    begin
                        elp_next = 32'sd0;
                        pc_next  = 4'd0;
                        lp_next  = 32'sd0;
                        smp_clr  = 1'b1;
                        sv_next  = 32'sd0;
                        st_next  = ST_OUT;
                    end
                    else
                    begin
                        if (s_tdata[1:0] != pm_reg)
                        begin
                            smp_clr  = 1'b1;
                            elp_next = 32'sd0;
                            pc_next  = 4'd0;
                            sv_next  = s_tdata[33:2];
                        end
                        st_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                // Near-end start test needs one multiply.
                mul_a = (md_reg == 2'd1) ? 32'sd65208 : 32'sd65;
                mul_b = {1'b0, full_reg};
                st_next = ST_TB;
                if (md_reg == pm_reg || (md_reg != 2'd1 && md_reg != 2'd2))
                    st_next = ST_TB;
                else
                    st_next = ST_TW;
                ti_next = 4'd0;
            end
            ST_TW:
            begin
                if ((md_reg == 2'd1 && vin_reg > mul_p) ||
                    (md_reg == 2'd2 && vin_reg < mul_p))
                    st_next = ST_OUT;
                else
                    st_next = ST_TB;
            end
            ST_TB:
            begin
                if (md_reg == 2'd1 || md_reg == 2'd2)
                begin
                    run_next = 1'b1;
                    ti_next  = 4'd0;
                    st_next  = ST_TM;
                end
                else
                begin
                    elp_next = 32'sd0;
                    run_next = 1'b0;
                    sv_next  = vin_reg;
                    pm_next  = md_reg;
                    st_next  = ST_OUT;
                end
            end
            ST_TM:
            begin
                // One time point per cycle from the shared product.
                tpt_wr = 1'b1;
                if (ti_reg == 4'd4)
                    tpt_val = base;
                else
                    tpt_val = sat32(66'($signed({9'd0, (tprod + 57'd8388608) >> 24})));
                if (ti_reg == 4'(NPTS - 1))
                    st_next = ST_ELP;
                else
                    ti_next = ti_reg + 4'd1;
            end
            ST_ELP:
            begin
                elp_next = sat32(66'(elp_reg) + 66'($signed({1'b0, tick_reg})));
                if (66'(elp_next) > 66'(tpt_reg[NPTS - 1]) + 66'sd16777216)
                    elp_next = 32'sd0;
                pm_next = md_reg;
                if (pc_reg < 4'(NPTS) && elp_next >= tpt_reg[pc_reg])
                begin
                    smp_wr  = 1'b1;
                    pc_next = pc_reg + 4'd1;
                    pj_next = pc_reg;
                    if (pc_reg != 4'd0)
                    begin
                        fi_next   = pc_reg - 4'd1;
                        fall_next = 1'b0;
                        st_next   = ST_FR;
                    end
                    else
                        st_next = ST_DEC;
                end
                else
                    st_next = ST_DEC;
            end
            ST_FR:
            begin
                // Line fit: slope denominator and target.
                den_next = sat32(66'(tpt_reg[fi_reg]) - 66'(tpt_reg[pj_reg])) >>> 8;
                mul_a = fr;
                mul_b = (md_reg == 2'd2) ? sv_reg
                        : sat32(66'($signed({1'b0, full_reg})) - 66'(sv_reg));
                st_next = ST_FRW;
            end
            ST_FRW:
            begin
                if (md_reg == 2'd2)
                    tg_next = mul_p;
                else
                    tg_next = sat32(66'(mul_p) + 66'(sv_reg));
                st_next = ST_K;
            end
            ST_K:
            begin
                div_start = 1'b1;
                div_num   = sat32(66'(smp_reg[fi_reg]) - 66'(smp_reg[pj_reg]));
                div_den   = den_reg;
                st_next   = ST_KW;
            end
            ST_KW:
            begin
                if (div_done)
                begin
                    k_next  = div_q;
                    st_next = ST_M1;
                end
            end
            ST_M1:
            begin
                mul_a   = tpt_reg[fi_reg];
                mul_b   = smp_reg[pj_reg];
                mul_q24 = 1'b1;
                st_next = ST_M1W;
            end
            ST_M1W:
            begin
                m1_next = mul_p;
                st_next = ST_M2;
            end
            ST_M2:
            begin
                mul_a   = tpt_reg[pj_reg];
                mul_b   = smp_reg[fi_reg];
                mul_q24 = 1'b1;
                st_next = ST_M2W;
            end
            ST_M2W:
            begin
                div_start = 1'b1;
                div_num   = sat32(66'(m1_reg) - 66'(mul_p));
                div_den   = den_reg;
                st_next   = ST_BW;
            end
            ST_BW:
            begin
                if (div_done)
                begin
                    b_next  = div_q;
                    st_next = ST_B;
                end
            end
            ST_B:
            begin
                div_start = 1'b1;
                div_num   = sat32(66'(tg_reg) - 66'(b_reg));
                div_den   = k_reg;
                st_next   = ST_TWT;
            end
            ST_TWT:
            begin
                if (div_done)
                begin
                    t_next  = div_q;
                    st_next = ST_T;
                end
            end
            ST_T:
            begin
                // Percent: t*100 then divide by the nominal time.
                mul_a   = t_reg;
                mul_b   = 32'sd6553600;
                st_next = ST_P1;
            end
            ST_P1:
            begin
                div_start = 1'b1;
                div_num   = mul_p;
                div_den   = tpt_reg[pj_reg] >>> 8;
                st_next   = ST_P1W;
            end
            ST_P1W:
            begin
                if (div_done)
                begin
                    pa_next = sat32(66'(div_q) - 66'sd6553600);
                    st_next = ST_P2;
                end
            end
            ST_P2:
            begin
                if (pa_reg < 0 && !fall_reg)
                begin
                    if (pj_reg >= 4'd8)
                    begin
                        run_next = 1'b0;
                        st_next  = ST_DEC;
                    end
                    else if (pj_reg >= 4'd2)
                    begin
                        fall_next = 1'b1;
                        fi_next   = (pj_reg >= 4'd6) ? pj_reg - 4'd3 : pj_reg - 4'd2;
                        st_next   = ST_FR;
                    end
                    else
                        st_next = ST_P2W;
                end
                else
                    st_next = ST_P2W;
            end
            ST_P2W:
            begin
                lp_next = t_reg;
                ld_next = pa_reg;
                if (pa_reg > upp_reg || pa_reg < low_reg)
                    alm_next = 1'b1;
                st_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (pc_reg == 4'(NPTS))
                begin
                    elp_next = 32'sd0;
                    run_next = 1'b0;
                end
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            elp_reg <= 32'sd0;
            pc_reg  <= 4'd0;
            sv_reg  <= 32'sd0;
            pm_reg  <= 2'd0;
            lp_reg  <= 32'sd0;
            ld_reg  <= 32'sd0;
            run_reg <= 1'b0;
            alm_reg <= 1'b0;
            for (int i = 0; i < NPTS; i++)
            begin
                smp_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            st_reg  <= st_next;
            elp_reg <= elp_next;
            pc_reg  <= pc_next;
            sv_reg  <= sv_next;
            pm_reg  <= pm_next;
            lp_reg  <= lp_next;
            ld_reg  <= ld_next;
            run_reg <= run_next;
            alm_reg <= alm_next;
            for (int i = 0; i < NPTS; i++)
            begin
                if (smp_clr)
                    smp_reg[i] <= 32'sd0;
                else if (smp_wr && pc_reg == 4'(i))
                    smp_reg[i] <= vin_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg   <= md_next;
        vin_reg  <= vin_next;
        ti_reg   <= ti_next;
        fi_reg   <= fi_next;
        pj_reg   <= pj_next;
        fall_reg <= fall_next;
        den_reg  <= den_next;
        k_reg    <= k_next;
        m1_reg   <= m1_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        tg_reg   <= tg_next;
        pa_reg   <= pa_next;
        if (tpt_wr)
            tpt_reg[ti_reg] <= tpt_val;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = {2'b00, pc_reg, ld_reg, lp_reg, alm_reg, run_reg};
endmodule

// File: dv/capacitor_time_constant_check_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capacitor_time_constant_check_test
// Self-checking bench for the capacitor time-constant check. Voltage ticks are
// streamed in and the status words coming out are compared with a bit-exact
// fixed-point predictor kept in the bench. Charge and discharge curves run
// under many register settings, with random idling and backpressure.
// ----------------------------------------------------------------------------
module capacitor_time_constant_check_test;

    import ctc_pkg::*;

    localparam int MAXV = 2147483647;
    localparam int MINV = -2147483648;

    // Register indexes.
    localparam int REG_FULL_VOLTAGE  = 0;
    localparam int REG_TIME_CONSTANT = 1;
    localparam int REG_TICK_TIME     = 2;
    localparam int REG_UPPER_LIMIT   = 3;
    localparam int REG_LOWER_LIMIT   = 4;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CHARGE    = 2'd1,
        MODE_DISCHARGE = 2'd2,
        MODE_HOLD      = 2'd3
    } test_mode_t;

    // Members from the highest bit down, matching the output word.
    typedef struct packed {
        logic [3:0]  point_index;
        logic [31:0] deviation;
        logic [31:0] predicted_time;
        logic        alarm;
        logic        running;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // mode[1:0], voltage[33:2], zero[39:34]
    logic        s_tuser;   // restart
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // running, alarm, predicted_time, deviation, point_index
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    capacitor_time_constant_check dut (.*);

    // Bench state.
    status_t expected_status[$];
    int      mismatches;
    int      checked;
    int      alarms_seen;
    int      full_sequences;
    bit      quiet_stretch;
    bit      hold_request;

    // Predictor copy of the registers and the block state.
    int        cfg_full, cfg_rc, cfg_tick, cfg_upper, cfg_lower;
    int        m_elapsed;
    int        m_points;
    int        m_samples[10];
    int        m_start;
    bit [1:0]  m_prev_mode;
    int        m_pred, m_dev;
    bit        m_running, m_alarm;
    int        m_tpt[10];

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Fixed-point helpers of the predictor
    // ------------------------------------------------------------------
    function automatic int clamp32(longint v);
        if (v > longint'(MAXV)) return MAXV;
        if (v < longint'(MINV)) return MINV;
        return int'(v);
    endfunction

    function automatic int mul_q16(int a, int b);
        return clamp32((longint'(a) * longint'(b)) >>> 16);
    endfunction

    function automatic int mul_q24(int a, int b);
        return clamp32((longint'(a) * longint'(b)) >>> 24);
    endfunction

    function automatic int div_q16(int a, int b);
        if (b == 0) return (a >= 0) ? MAXV : MINV;
        return clamp32((longint'(a) * 65536) / longint'(b));
    endfunction

    function automatic int to_q16(int a);
        return a >>> 8;
    endfunction

    function automatic int swing_fraction(int j, bit [1:0] md);
        int ch[10];
        int dis[10];
        ch  = '{11796, 21626, 29491, 36044, 41287, 48234, 53084, 56688, 60162, 62259};
        dis = '{53739, 43909, 36044, 29491, 24248, 17301, 12451, 8847, 5373, 3276};
        return (md == MODE_DISCHARGE) ? dis[j] : ch[j];
    endfunction

    // Line through samples i and j, time at which it meets the target level.
    function automatic int crossing_time(int i, int j, bit [1:0] md, int frac);
        int den, slope, icpt, target;
        den   = to_q16(clamp32(longint'(m_tpt[i]) - m_tpt[j]));
        slope = div_q16(clamp32(longint'(m_samples[i]) - m_samples[j]), den);
        icpt  = div_q16(clamp32(longint'(mul_q24(m_tpt[i], m_samples[j]))
                                - mul_q24(m_tpt[j], m_samples[i])), den);
        if (md == MODE_DISCHARGE)
            target = mul_q16(frac, m_start);
        else
            target = clamp32(longint'(mul_q16(frac, clamp32(longint'(cfg_full) - m_start)))
                             + m_start);
        return div_q16(clamp32(longint'(target) - icpt), slope);
    endfunction

    function automatic int deviation_pct(int t, int j);
        return clamp32(longint'(div_q16(mul_q16(t, 6553600), to_q16(m_tpt[j]))) - 6553600);
    endfunction

    function automatic void check_sample_point(int j, bit [1:0] md);
        int frac, t;
        frac = swing_fraction(j, md);
        t = crossing_time(j - 1, j, md, frac);
        if (deviation_pct(t, j) < 0) begin
            // Late points with a negative first estimate make no prediction.
            if (j >= 8) begin
                m_running = 1'b0;
                return;
            end
            if (j >= 6) t = crossing_time(j - 3, j, md, frac);
            else if (j >= 2) t = crossing_time(j - 2, j, md, frac);
        end
        m_pred = t;
        m_dev  = deviation_pct(t, j);
        if (m_dev > cfg_upper || m_dev < cfg_lower) m_alarm = 1'b1;
    endfunction

    function automatic void advance_test(bit [1:0] md, int v);
        longint mult[10];
        int     base;
        mult = '{3355443, 6710886, 10066329, 13421772, 16777216,
                 22313697, 27850178, 33554432, 41943040, 50331648};
        base = clamp32(longint'(cfg_rc) * 256);
        for (int i = 0; i < 10; i++)
            m_tpt[i] = (i == 4) ? base : clamp32((mult[i] * base + 8388608) >>> 24);
        m_running = 1'b1;
        m_elapsed = clamp32(longint'(m_elapsed) + cfg_tick);
        // Timer overrun past the last point returns to zero.
        if (longint'(m_elapsed) > longint'(m_tpt[9]) + 16777216) m_elapsed = 0;
        if (m_points < 10 && m_elapsed >= m_tpt[m_points]) begin
            m_samples[m_points] = v;
            if (m_points != 0) check_sample_point(m_points, md);
            m_points++;
        end
    endfunction

    function automatic status_t current_status();
        status_t s;
        s.running        = m_running;
        s.alarm          = m_alarm;
        s.predicted_time = m_pred;
        s.deviation      = m_dev;
        s.point_index    = m_points[3:0];
        return s;
    endfunction

    // Updates the predictor for one tick and returns the status it yields.
    function automatic status_t predict_tick(bit rs, bit [1:0] md, int v);
        if (rs) begin
            m_elapsed = 0;
            m_points  = 0;
            m_pred    = 0;
            m_samples = '{default: 0};
            m_start   = 0;
            return current_status();
        end
        if (md != m_prev_mode) begin
            m_samples = '{default: 0};
            m_elapsed = 0;
            m_points  = 0;
            m_start   = v;
            // Start level already near the end value: the test is skipped.
            if ((md == MODE_CHARGE && v > mul_q16(65208, cfg_full)) ||
                (md == MODE_DISCHARGE && v < mul_q16(65, cfg_full)))
                return current_status();
        end
        if (md == MODE_CHARGE || md == MODE_DISCHARGE) begin
            advance_test(md, v);
            if (m_points == 10) begin
                m_elapsed = 0;
                m_running = 1'b0;
            end
        end else begin
            m_elapsed = 0;
            m_running = 1'b0;
            m_start   = v;
        end
        m_prev_mode = md;
        return current_status();
    endfunction

    // ------------------------------------------------------------------
    // Register writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(int idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FULL_VOLTAGE:  cfg_full  = int'({1'b0, value[30:0]});
            REG_TIME_CONSTANT: cfg_rc    = int'({1'b0, value[30:0]});
            REG_TICK_TIME:     cfg_tick  = int'({1'b0, value[30:0]});
            REG_UPPER_LIMIT:   cfg_upper = int'(value);
            REG_LOWER_LIMIT:   cfg_lower = int'(value);
            default: ;
        endcase
    endtask

    task automatic write_all(int full, int rc, int tick, int upper, int lower);
        write_reg(REG_FULL_VOLTAGE, full);
        write_reg(REG_TIME_CONSTANT, rc);
        write_reg(REG_TICK_TIME, tick);
        write_reg(REG_UPPER_LIMIT, upper);
        write_reg(REG_LOWER_LIMIT, lower);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_tick(bit rs, bit [1:0] md, int v);
        if (!quiet_stretch && $urandom_range(99) < 14) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rs;
        s_tdata  <= {6'd0, v, md};
        do @(posedge clk); while (!s_tready);
        expected_status.push_back(predict_tick(rs, md, v));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Sender pause until every outstanding status has come back.
    task automatic drain();
        stop_sending();
        while (expected_status.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Voltage of an ideal curve after n ticks, with a little noise.
    function automatic int curve_voltage(bit [1:0] md, int n, int start, int noise);
        real tau, dt, x;
        tau = real'(cfg_rc) / 65536.0;
        dt  = real'(cfg_tick) / 16777216.0;
        x   = (tau > 0.0) ? $exp(-(n * dt) / tau) : 0.0;
        if (md == MODE_DISCHARGE)
            return $rtoi(real'(start) * x) + noise;
        return $rtoi(real'(cfg_full) - real'(cfg_full - start) * x) + noise;
    endfunction

    // A full test: idle tick, then ticks until all points are taken or max_ticks is reached.
    task automatic run_curve(bit [1:0] md, int noise_span, int max_ticks);
        int start, n;
        start = (md == MODE_DISCHARGE) ? cfg_full : 0;
        send_tick(1'b0, MODE_IDLE, start);
        n = 0;
        do begin
            n++;
            send_tick(1'b0, md, curve_voltage(md, n, start,
                      $urandom_range(2 * noise_span) - noise_span));
        end while (m_points < 10 && n < max_ticks);
        if (m_points == 10) full_sequences++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Default registers: full voltage zero, so a charge start above zero or a discharge start below zero skips.
        send_tick(1'b0, MODE_CHARGE, 32'sd100);
        send_tick(1'b0, MODE_CHARGE, MAXV);
        send_tick(1'b0, MODE_DISCHARGE, MINV);
        send_tick(1'b0, MODE_HOLD, 32'sd0);
        send_tick(1'b1, MODE_DISCHARGE, MAXV);
        send_tick(1'b0, MODE_IDLE, MINV);
        send_tick(1'b0, MODE_CHARGE, -32'sd5);
        send_tick(1'b0, MODE_CHARGE, MINV);
        drain();
        // Large tick: check points are reached quickly, at most one per tick.
        write_all(655360, 65536, 3355443, 1310720, -1310720);
        run_curve(MODE_CHARGE, 0, 12);
        run_curve(MODE_DISCHARGE, 0, 12);
        send_tick(1'b1, MODE_DISCHARGE, 32'sd0);
        drain();
        // Zero time constant makes every fit divide by zero.
        write_reg(REG_TIME_CONSTANT, 0);
        send_tick(1'b0, MODE_CHARGE, 32'sd0);
        send_tick(1'b0, MODE_CHARGE, 32'sd1000);
        send_tick(1'b0, MODE_CHARGE, MAXV);
        drain();
    endtask

    task automatic test_register_extremes();
        write_all(MAXV, MAXV, MAXV, MAXV, MINV);
        send_tick(1'b0, MODE_IDLE, 32'sd0);
        repeat (6) send_tick(1'b0, MODE_CHARGE, $urandom());
        send_tick(1'b0, MODE_DISCHARGE, MAXV);
        repeat (6) send_tick(1'b0, MODE_DISCHARGE, $urandom());
        drain();
        write_all(0, 1, 0, MINV, MAXV);
        repeat (4) send_tick(1'b0, MODE_CHARGE, $urandom());
        send_tick(1'b0, MODE_DISCHARGE, 32'sd7);
        drain();
        write_all(65536, 3, MAXV, 0, 0);
        repeat (8) send_tick(1'b0, 2'($urandom_range(3)), $urandom());
        drain();
    endtask

    task automatic test_random_sequences(int target);
        int sent, rc, span;
        bit [1:0] md;
        sent = 0;
        while (sent < target) begin
            // Mostly small time constants and a few ticks per point.
            rc = ($urandom_range(9) == 0) ? $urandom() & 32'h7fffffff
                                          : $urandom_range(256, 600000);
            write_all($urandom_range(65536, 16777216), rc,
                      ($urandom_range(5) == 0) ? $urandom() & 32'h7fffffff
                        : clamp32(longint'(rc) * 256 / $urandom_range(2, 12)),
                      $urandom_range(0, 6553600), -$urandom_range(0, 6553600));
            for (int k = 0; k < 6; k++) begin
                md   = $urandom_range(1) ? MODE_CHARGE : MODE_DISCHARGE;
                span = $urandom_range(3) == 0 ? 40000 : 300;
                case ($urandom_range(9))
                    0: begin
                        // Noise and broken sequences.
                        repeat (8) send_tick($urandom_range(7) == 0,
                                             2'($urandom_range(3)), $urandom());
                        sent += 8;
                    end
                    1: begin
                        run_curve(md, span, 5);
                        send_tick(1'b1, md, $urandom());
                        sent += 7;
                    end
                    default: begin
                        run_curve(md, span, 60);
                        sent += m_points + 2;
                    end
                endcase
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_all(655360, 65536, 3355443, 1310720, -1310720);
        hold_request = 1'b1;
        run_curve(MODE_CHARGE, 100, 12);
        run_curve(MODE_DISCHARGE, 100, 12);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        int hold_count;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            hold_count = 0;
        end else if (hold_request) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count == 400) begin
                hold_request = 1'b0;
                hold_count   = 0;
            end
        end else begin
            m_tready <= quiet_stretch || ($urandom_range(99) >= 14);
        end
    end

    // Compare each status transfer with the oldest prediction.
    always @(posedge clk)
    begin
        status_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[69:0];
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status %h with no prediction pending", got);
            end else begin
                want = expected_status.pop_front();
                checked++;
                if (got.alarm) alarms_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: run %b/%b alarm %b/%b time %h/%h dev %h/%h idx %0d/%0d",
                                 want.running, got.running, want.alarm, got.alarm,
                                 want.predicted_time, got.predicted_time,
                                 want.deviation, got.deviation,
                                 want.point_index, got.point_index);
                end
            end
        end
    end

    // Time limit.
    initial
    begin
        #60ms;
        $display("capacitor_time_constant_check: mismatch");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        checked = 0;
        alarms_seen = 0;
        full_sequences = 0;
        quiet_stretch = 1'b0;
        hold_request = 1'b0;
        cfg_full = 0;
        cfg_rc = 65536;
        cfg_tick = 16777;
        cfg_upper = 1310720;
        cfg_lower = -1310720;
        m_elapsed = 0;
        m_points = 0;
        m_samples = '{default: 0};
        m_tpt = '{default: 0};
        m_start = 0;
        m_prev_mode = MODE_IDLE;
        m_pred = 0;
        m_dev = 0;
        m_running = 1'b0;
        m_alarm = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_random_sequences(400);
        quiet_stretch = 1'b1;
        test_random_sequences(150);
        quiet_stretch = 1'b0;
        test_backpressure();
        test_random_sequences(300);

        // Let the last results come back.
        stop_sending();
        wait_cycles = 0;
        while (expected_status.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        $display("Checked %0d status transfers, %0d with alarm set.", checked, alarms_seen);
        $display("Completed %0d ten-point charge/discharge tests.", full_sequences);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("capacitor_time_constant_check: match");
        else
            $display("capacitor_time_constant_check: mismatch");
        $finish;
    end

endmodule
